>>> rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
`default_nettype none
package lkvc_pkg;

  localparam int KEY_PORT_W   = 32;
  localparam int DATA_W       = 32;
  localparam int CAP_W        = 5;
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // word index of each configuration register
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t               command;
    logic [KEY_PORT_W-1:0]   lookup_key;
    logic signed [DATA_W-1:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic [KEY_PORT_W-1:0]    evicted_key;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/lkvc_cfg.sv
// APB-style register block holding the capacity limit.
`default_nettype none
module lkvc_cfg
  import lkvc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [CAP_W-1:0]   capacity
);

  logic [CAP_W-1:0] cap_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (wr_en && (paddr[2] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = PDATA_W'(cap_r);
    end
  end

  assign capacity = cap_r;

endmodule
`default_nettype wire

>>> rtl/lkvc_in_stage.sv
// Input register: captures one command and holds it until the core takes it.
`default_nettype none
module lkvc_in_stage
  import lkvc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cmd_t in_cmd,
  input  wire logic advance,
  output logic      stage_valid,
  output cmd_t      stage_cmd
);

  logic v_r;
  cmd_t cmd_r;

  assign in_ready = !v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
    end
  end

  assign stage_valid = v_r;
  assign stage_cmd   = cmd_r;

endmodule
`default_nettype wire

>>> rtl/lkvc_core.sv
// Entry store with parallel key match, rank aging and replacement choice.
`default_nettype none
module lkvc_core
  import lkvc_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CAP_W-1:0] capacity,
  input  wire logic             fire,
  input  wire cmd_t             cmd,
  output res_t                  res
);

  localparam int KW = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IW = RW;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  logic [ENTRIES-1:0]       valid_r;
  logic [KW-1:0]            key_r  [ENTRIES];
  logic [DATA_W-1:0]        val_r  [ENTRIES];
  logic [RW-1:0]            rank_r [ENTRIES];
  logic [CW-1:0]            occ_r;

  logic [KW-1:0]      key;
  logic               is_put;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] fresh;
  logic [ENTRIES-1:0] sel;
  logic               hit;
  logic [DATA_W-1:0]  m_val;
  logic [RW-1:0]      m_rank;
  logic [KW-1:0]      v_key;
  logic [EW-1:0]      cap_e;
  logic [EW-1:0]      eff_cap;
  logic               full;
  logic [CW-1:0]      occ_m1;
  logic [CW-1:0]      age_limit;
  logic               do_update;
  logic               do_insert;
  logic               do_evict;

  assign key    = cmd.lookup_key[KW-1:0];
  assign is_put = (cmd.command == CMD_PUT);
  assign occ_m1 = occ_r - CW'(1);

  // clamp capacity into 1..ENTRIES
  always_comb begin
    cap_e = EW'(capacity);
    if (cap_e == '0) begin
      eff_cap = EW'(1);
    end else if (cap_e > EW'(ENTRIES)) begin
      eff_cap = EW'(ENTRIES);
    end else begin
      eff_cap = cap_e;
    end
  end

  assign full = (EW'(occ_r) >= eff_cap);

  // Entries fill in index order and never leave, so the free slot is at occ_r
  // and the LRU entry holds rank occ_r - 1.
  always_comb begin
    m_val  = '0;
    m_rank = '0;
    v_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == key);
      victim[i] = valid_r[i] && (CW'(rank_r[i]) == occ_m1);
      fresh[i]  = (IW'(i) == occ_r[IW-1:0]);
      m_val     = m_val  | ({DATA_W{match[i]}} & val_r[i]);
      m_rank    = m_rank | ({RW{match[i]}} & rank_r[i]);
      v_key     = v_key  | ({KW{victim[i]}} & key_r[i]);
    end
  end

  assign hit       = |match;
  assign do_update = fire && (hit || is_put);
  assign do_evict  = fire && is_put && !hit && full;
  assign do_insert = fire && is_put && !hit && !full;

  always_comb begin
    if (hit) begin
      sel       = match;
      age_limit = CW'(m_rank);
    end else if (full) begin
      sel       = victim;
      age_limit = occ_m1;
    end else begin
      sel       = fresh;
      age_limit = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else begin
      if (do_update) begin
        valid_r <= valid_r | sel;
      end
      if (do_insert) begin
        occ_r <= occ_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_update) begin
        if (sel[i]) begin
          rank_r[i] <= '0;
          if (is_put) begin
            key_r[i] <= key;
            val_r[i] <= cmd.write_value;
          end
        end else if (valid_r[i] && (CW'(rank_r[i]) < age_limit)) begin
          rank_r[i] <= rank_r[i] + RW'(1);
        end
      end
    end
  end

  always_comb begin
    res.hit         = hit;
    res.read_value  = (hit && !is_put) ? m_val : '0;
    res.evicted     = is_put && !hit && full;
    res.evicted_key = (is_put && !hit && full) ? KEY_PORT_W'(v_key) : '0;
  end

`ifndef SYNTHESIS
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> $onehot0(match))
    else $error("key matches more than one entry");

  a_victim_one: assert property (@(posedge clk) disable iff (!rst_n)
    do_evict |-> $onehot(victim))
    else $error("no single least recent entry at eviction");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> (occ_r == $past(occ_r) + CW'(1)))
    else $error("occupancy did not advance on insert");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && hit) |=> $stable(occ_r))
    else $error("occupancy changed on a hit");

  a_occ_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> ($countones(valid_r) == int'(occ_r)))
    else $error("valid marks disagree with occupancy");
`endif

endmodule
`default_nettype wire

>>> rtl/lkvc_out_stage.sv
// Result register: holds one result until the consumer takes it.
`default_nettype none
module lkvc_out_stage
  import lkvc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res_in,
  output logic      can_load,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res_out
);

  logic v_r;
  res_t res_r;

  assign can_load = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (can_load) begin
      v_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = v_r;
  assign res_out   = res_r;

endmodule
`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// Top level of the fully associative key/value cache with LRU replacement.
`default_nettype none
// Fully associative key/value cache, up to ENTRIES pairs, least-recently-used
// replacement. Each command (get or put) is captured in an input register,
// matched against every valid entry at once, and its result is loaded into an
// output register at the same edge that updates the entry state, so the next
// command sees it. Throughput is one command per clock while the result side
// does not stall; the input and result registers sit around the single
// compare/age/replace pass. The input side keeps taking commands while a
// result waits, until both registers are full. Entries fill in index order
// and recency is one rank per entry (0 is most recent). The capacity
// register (word 0) limits occupancy, clamped into 1..ENTRIES; lowering it
// below the current fill makes every new-key put evict without ever
// shrinking the fill. Only valid marks and the fill count are reset, so there
// is no clearing pass: the block is ready right after reset. Keys are
// truncated to KEY_BITS on entry and zero-extended on output.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // command channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_command,
  input  wire logic [KEY_PORT_W-1:0]    in_lookup_key,
  input  wire logic signed [DATA_W-1:0] in_write_value,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_hit,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic                          out_evicted,
  output logic [KEY_PORT_W-1:0]         out_evicted_key,
  // configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [PDATA_W-1:0]       pwdata,
  output logic      [PDATA_W-1:0]       prdata,
  output logic                          pready
);

  logic             stage_valid;
  cmd_t             in_cmd;
  cmd_t             stage_cmd;
  res_t             core_res;
  res_t             out_res;
  logic             can_load;
  logic             advance;
  logic [CAP_W-1:0] capacity;

  // pack the command fields for the input register
  always_comb begin
    in_cmd.command     = cmd_code_t'(in_command);
    in_cmd.lookup_key  = in_lookup_key;
    in_cmd.write_value = in_write_value;
  end

  // advance the held command when the result register has room
  assign advance = stage_valid && can_load;

  lkvc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lkvc_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_cmd   (stage_cmd)
  );

  lkvc_core #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity),
    .fire     (advance),
    .cmd      (stage_cmd),
    .res      (core_res)
  );

  lkvc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_in    (core_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (out_res)
  );

  // drive the result fields from the result register
  assign out_hit         = out_res.hit;
  assign out_read_value  = out_res.read_value;
  assign out_evicted     = out_res.evicted;
  assign out_evicted_key = out_res.evicted_key;

endmodule
`default_nettype wire
